// ----- rtl/x86_group3_unary_muldiv_alu_core_macros.svh -----
// Assertion macros for the group-3 execution core.
`ifndef X86_GROUP3_UNARY_MULDIV_ALU_CORE_MACROS_SVH
`define X86_GROUP3_UNARY_MULDIV_ALU_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define G3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define G3_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/x86g3_pkg.sv -----
// Shared types, codes and helper functions of the group-3 execution core.
package x86g3_pkg;

    localparam logic [2:0] CMD_TEST = 3'd0;
    localparam logic [2:0] CMD_NOT  = 3'd1;
    localparam logic [2:0] CMD_NEG  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_IMUL = 3'd4;
    localparam logic [2:0] CMD_DIV  = 3'd5;
    localparam logic [2:0] CMD_IDIV = 3'd6;

    localparam int FL_CF = 0;
    localparam int FL_PF = 2;
    localparam int FL_AF = 4;
    localparam int FL_ZF = 6;
    localparam int FL_SF = 7;
    localparam int FL_OF = 11;

    // Quotient steps resolved in each divider stage.
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = 16 / DIV_STEPS;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        word;
        logic [15:0] opnd;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [15:0] flags;
        logic [15:0] simple_res;
        logic [15:0] simple_flags;
        logic [31:0] prod;
        logic [4:0]  cost;
        logic        div_ok;
        logic        q_neg;
        logic        r_neg;
    } ctl_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] quo;
        logic [15:0] dvsr;
    } div_t;

    function automatic logic [15:0] set_szp(input logic [15:0] fl, input logic [15:0] res,
                                            input logic word);
        logic [15:0] f;
        f = fl;
        f[FL_SF] = word ? res[15] : res[7];
        f[FL_ZF] = word ? (res == 16'h0000) : (res[7:0] == 8'h00);
        f[FL_PF] = ~^res[7:0];
        return f;
    endfunction

    function automatic logic [4:0] op_cost(input logic [2:0] cmd, input logic word,
                                           input logic regop);
        logic [4:0] c;
        unique case (cmd)
            CMD_TEST:          c = regop ? 5'd2 : 5'd6;
            CMD_NOT, CMD_NEG:  c = regop ? 5'd2 : 5'd7;
            CMD_MUL, CMD_IMUL: c = word ? (regop ? 5'd21 : 5'd24) : (regop ? 5'd13 : 5'd16);
            CMD_DIV:           c = word ? (regop ? 5'd22 : 5'd25) : (regop ? 5'd14 : 5'd17);
            CMD_IDIV:          c = word ? (regop ? 5'd25 : 5'd28) : (regop ? 5'd17 : 5'd20);
            default:           c = 5'd2;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/x86g3_front.sv -----
// Front stage: decode, simple ops, multiply, divider operand setup.
module x86g3_front import x86g3_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        in_valid,
    input  logic [2:0]  cmd,
    input  logic        word_size,
    input  logic        register_operand,
    input  logic [15:0] operand_in,
    input  logic [15:0] immediate,
    input  logic [15:0] ax_in,
    input  logic [15:0] dx_in,
    input  logic [15:0] flags_in,
    output logic        out_valid,
    output ctl_t        out_ctl,
    output div_t        out_div
);
    logic        valid_reg;
    ctl_t        ctl_reg, ctl_next;
    div_t        div_reg, div_next;
    logic [15:0] src, mask, res_test, res_neg, fl_test, fl_neg;
    logic        msign, idiv, n_neg, d_neg;
    logic [16:0] ma, mb, d17, dmag17;
    logic [33:0] prod34;
    logic [31:0] n32, nmag;
    logic [15:0] chk;

    always_comb begin
        mask = word_size ? 16'hffff : 16'h00ff;
        src  = operand_in & mask;

        res_test = src & immediate & mask;
        fl_test = flags_in;
        fl_test[FL_CF] = 1'b0;
        fl_test[FL_OF] = 1'b0;
        fl_test = set_szp(fl_test, res_test, word_size);

        res_neg = (16'h0000 - src) & mask;
        fl_neg = flags_in;
        fl_neg[FL_CF] = (src != 16'h0000);
        fl_neg[FL_OF] = word_size ? (src == 16'h8000) : (src == 16'h0080);
        fl_neg[FL_AF] = src[4] ^ res_neg[4];
        fl_neg = set_szp(fl_neg, res_neg, word_size);

        msign  = (cmd == CMD_IMUL);
        ma     = word_size ? {msign & ax_in[15], ax_in} : {{9{msign & ax_in[7]}}, ax_in[7:0]};
        mb     = word_size ? {msign & operand_in[15], operand_in}
                           : {{9{msign & operand_in[7]}}, operand_in[7:0]};
        prod34 = 34'($signed(ma) * $signed(mb));

        idiv   = (cmd == CMD_IDIV);
        n32    = word_size ? {dx_in, ax_in} : {{16{idiv & ax_in[15]}}, ax_in};
        n_neg  = idiv & n32[31];
        nmag   = n_neg ? (~n32 + 32'd1) : n32;
        d17    = word_size ? {idiv & operand_in[15], operand_in}
                           : {{9{idiv & operand_in[7]}}, operand_in[7:0]};
        d_neg  = d17[16];
        dmag17 = d_neg ? (~d17 + 17'd1) : d17;
        chk    = word_size ? nmag[31:16] : {8'h00, nmag[15:8]};

        ctl_next.cmd          = cmd;
        ctl_next.word         = word_size;
        ctl_next.opnd         = operand_in;
        ctl_next.ax           = ax_in;
        ctl_next.dx           = dx_in;
        ctl_next.flags        = flags_in;
        ctl_next.simple_res   = (cmd == CMD_NEG) ? res_neg : (~src & mask);
        ctl_next.simple_flags = (cmd == CMD_NEG) ? fl_neg : fl_test;
        ctl_next.prod         = prod34[31:0];
        ctl_next.cost         = op_cost(cmd, word_size, register_operand);
        ctl_next.div_ok       = (dmag17[15:0] != 16'h0000) && (chk < dmag17[15:0]);
        ctl_next.q_neg        = idiv & (n_neg ^ d_neg);
        ctl_next.r_neg        = n_neg;

        div_next.rem  = word_size ? nmag[31:16] : 16'h0000;
        div_next.quo  = nmag[15:0];
        div_next.dvsr = dmag17[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ctl_reg <= ctl_next;
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_div   = div_reg;
endmodule

// ----- rtl/x86g3_div_stage.sv -----
// One divider stage: a few restoring quotient steps, then a register.
module x86g3_div_stage import x86g3_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  logic in_valid,
    input  ctl_t in_ctl,
    input  div_t in_div,
    output logic out_valid,
    output ctl_t out_ctl,
    output div_t out_div
);
    logic valid_reg;
    ctl_t ctl_reg;
    div_t div_reg, div_next;

    always_comb begin
        logic [16:0] diff;
        div_next = in_div;
        for (int i = 0; i < DIV_STEPS; i++) begin
            diff = {div_next.rem, div_next.quo[15]} - {1'b0, div_next.dvsr};
            if (!diff[16]) begin
                div_next.rem = diff[15:0];
                div_next.quo = {div_next.quo[14:0], 1'b1};
            end else begin
                div_next.rem = {div_next.rem[14:0], div_next.quo[15]};
                div_next.quo = {div_next.quo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ctl_reg <= in_ctl;
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_div   = div_reg;
endmodule

// ----- rtl/x86g3_finish.sv -----
// Finish stage: sign fix, range check, write-back selection, output register.
module x86g3_finish import x86g3_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        in_valid,
    input  ctl_t        in_ctl,
    input  div_t        in_div,
    output logic        m_valid,
    output logic [15:0] m_operand_out,
    output logic        m_operand_write,
    output logic [15:0] m_ax_out,
    output logic        m_ax_write,
    output logic [15:0] m_dx_out,
    output logic        m_dx_write,
    output logic [15:0] m_flags_out,
    output logic        m_divide_error,
    output logic [4:0]  m_cycle_cost
);
    logic        valid_reg;
    logic [15:0] op_reg, op_next, ax_reg, ax_next, dx_reg, dx_next, fl_reg, fl_next;
    logic        opw_reg, opw_next, axw_reg, axw_next, dxw_reg, dxw_next;
    logic        derr_reg, derr_next;
    logic [4:0]  cost_reg;
    logic [15:0] q, r, qs, rs;
    logic        mul_ovf, range_bad;

    always_comb begin
        q  = in_div.quo;
        r  = in_div.rem;
        qs = in_ctl.q_neg ? (~q + 16'd1) : q;
        rs = in_ctl.r_neg ? (~r + 16'd1) : r;

        if (in_ctl.word) begin
            range_bad = in_ctl.q_neg ? (q > 16'h8000) : (q > 16'h7fff);
        end else begin
            range_bad = in_ctl.q_neg ? (q > 16'h0080) : (q > 16'h007f);
        end

        if (in_ctl.cmd == CMD_IMUL) begin
            mul_ovf = in_ctl.word ? !((&in_ctl.prod[31:15]) || !(|in_ctl.prod[31:15]))
                                  : !((&in_ctl.prod[15:7]) || !(|in_ctl.prod[15:7]));
        end else begin
            mul_ovf = in_ctl.word ? (in_ctl.prod[31:16] != 16'h0000)
                                  : (in_ctl.prod[15:8] != 8'h00);
        end

        op_next   = in_ctl.opnd;
        ax_next   = in_ctl.ax;
        dx_next   = in_ctl.dx;
        fl_next   = in_ctl.flags;
        opw_next  = 1'b0;
        axw_next  = 1'b0;
        dxw_next  = 1'b0;
        derr_next = 1'b0;

        case (in_ctl.cmd)
            CMD_TEST: begin
                fl_next = in_ctl.simple_flags;
            end
            CMD_NOT: begin
                op_next  = in_ctl.simple_res;
                opw_next = 1'b1;
            end
            CMD_NEG: begin
                op_next  = in_ctl.simple_res;
                opw_next = 1'b1;
                fl_next  = in_ctl.simple_flags;
            end
            CMD_MUL, CMD_IMUL: begin
                ax_next  = in_ctl.prod[15:0];
                axw_next = 1'b1;
                if (in_ctl.word) begin
                    dx_next  = in_ctl.prod[31:16];
                    dxw_next = 1'b1;
                end
                fl_next[FL_CF] = mul_ovf;
                fl_next[FL_OF] = mul_ovf;
            end
            CMD_DIV, CMD_IDIV: begin
                derr_next = !in_ctl.div_ok || ((in_ctl.cmd == CMD_IDIV) && range_bad);
                if (!derr_next) begin
                    axw_next = 1'b1;
                    if (in_ctl.word) begin
                        ax_next  = qs;
                        dx_next  = rs;
                        dxw_next = 1'b1;
                    end else begin
                        ax_next = {rs[7:0], qs[7:0]};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            op_reg   <= op_next;
            opw_reg  <= opw_next;
            ax_reg   <= ax_next;
            axw_reg  <= axw_next;
            dx_reg   <= dx_next;
            dxw_reg  <= dxw_next;
            fl_reg   <= fl_next;
            derr_reg <= derr_next;
            cost_reg <= in_ctl.cost;
        end
    end

    assign m_valid         = valid_reg;
    assign m_operand_out   = op_reg;
    assign m_operand_write = opw_reg;
    assign m_ax_out        = ax_reg;
    assign m_ax_write      = axw_reg;
    assign m_dx_out        = dx_reg;
    assign m_dx_write      = dxw_reg;
    assign m_flags_out     = fl_reg;
    assign m_divide_error  = derr_reg;
    assign m_cycle_cost    = cost_reg;
endmodule

// ----- rtl/x86_group3_unary_muldiv_alu_core.sv -----
// Group-3 execution core (TEST/NOT/NEG/MUL/IMUL/DIV/IDIV): pipeline top level.
//
// Usage:
//   Present one instruction on the s_ channel (command, size, operand kind,
//   operand, immediate, AX, DX, flags) with s_valid; it transfers when
//   s_valid and s_ready are both high. One result per instruction leaves on
//   the m_ channel (new operand/AX/DX with write strobes, flags, divide
//   error, clock cost) and transfers when m_valid and m_ready are high.
//   Pipeline: the item passes six register stages (front stage with the
//   multiplier, four divider stages of four quotient steps, finish stage).
//   Throughput: one instruction per cycle when not stalled; the 16-step divider
//   is spread over the four divider stages so every stage takes a new item each
//   cycle the pipe advances. Results leave in input order.
//   Stall: when m_valid is high and m_ready low, the whole pipe holds and
//   s_ready drops; nothing is lost or repeated.
//   Reset: aresetn low clears every stage valid bit; no result is pending
//   afterwards and s_ready is high.
`include "x86_group3_unary_muldiv_alu_core_macros.svh"
module x86_group3_unary_muldiv_alu_core import x86g3_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic        s_word_size,
    input  logic        s_register_operand,
    input  logic [15:0] s_operand_in,
    input  logic [15:0] s_immediate,
    input  logic [15:0] s_ax_in,
    input  logic [15:0] s_dx_in,
    input  logic [15:0] s_flags_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_operand_out,
    output logic        m_operand_write,
    output logic [15:0] m_ax_out,
    output logic        m_ax_write,
    output logic [15:0] m_dx_out,
    output logic        m_dx_write,
    output logic [15:0] m_flags_out,
    output logic        m_divide_error,
    output logic [4:0]  m_cycle_cost
);
    // Advance every stage whenever the output register is free or drains.
    logic advance;
    logic vld [DIV_STAGES+1];
    ctl_t ctl [DIV_STAGES+1];
    div_t dv  [DIV_STAGES+1];

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    x86g3_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .in_valid         (s_valid),
        .cmd              (s_cmd),
        .word_size        (s_word_size),
        .register_operand (s_register_operand),
        .operand_in       (s_operand_in),
        .immediate        (s_immediate),
        .ax_in            (s_ax_in),
        .dx_in            (s_dx_in),
        .flags_in         (s_flags_in),
        .out_valid        (vld[0]),
        .out_ctl          (ctl[0]),
        .out_div          (dv[0])
    );

    // Chain of divider stages; control travels alongside the partial quotient.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        x86g3_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (vld[g]),
            .in_ctl    (ctl[g]),
            .in_div    (dv[g]),
            .out_valid (vld[g+1]),
            .out_ctl   (ctl[g+1]),
            .out_div   (dv[g+1])
        );
    end

    x86g3_finish u_finish (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .in_valid        (vld[DIV_STAGES]),
        .in_ctl          (ctl[DIV_STAGES]),
        .in_div          (dv[DIV_STAGES]),
        .m_valid         (m_valid),
        .m_operand_out   (m_operand_out),
        .m_operand_write (m_operand_write),
        .m_ax_out        (m_ax_out),
        .m_ax_write      (m_ax_write),
        .m_dx_out        (m_dx_out),
        .m_dx_write      (m_dx_write),
        .m_flags_out     (m_flags_out),
        .m_divide_error  (m_divide_error),
        .m_cycle_cost    (m_cycle_cost)
    );

    // A faulting divide writes nothing back.
    `G3_ASSERT(a_derr_no_write, m_valid && m_divide_error |-> !m_ax_write && !m_dx_write && !m_operand_write, "divide error with write strobe")
    // DX is only written together with AX.
    `G3_ASSERT(a_dx_with_ax, m_valid && m_dx_write |-> m_ax_write, "DX write without AX write")
    // The pipe is empty right after reset.
    `G3_ASSERT_ALWAYS(a_reset_empty, $past(!aresetn) |-> !m_valid && !vld[0], "valid after reset")
    // Cost stays within the instruction table.
    `G3_ASSERT(a_cost_range, m_valid |-> m_cycle_cost >= 5'd2 && m_cycle_cost <= 5'd28, "cost out of range")
endmodule
